### rtl/core/trwse_pkg.sv
// ----------------------------------------------------------------------------
// trwse_pkg
// shared types and constants of the transaction read/write-set engine
// ----------------------------------------------------------------------------
package trwse_pkg;

    localparam int NUM_VARS_DEF      = 256;
    localparam int READ_SET_MAX_DEF  = 16;
    localparam int WRITE_SET_MAX_DEF = 16;
    localparam int NUM_CONTEXTS_DEF  = 4;
    localparam int DATA_WIDTH_DEF    = 32;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_SWAP   = 3'd2;
    localparam logic [2:0] OP_CAS    = 3'd3;
    localparam logic [2:0] OP_COMMIT = 3'd4;
    localparam logic [2:0] OP_ABORT  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  context_req;
        logic [7:0]  var_index;
        logic [31:0] write_value;
        logic [31:0] expected_value;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [4:0] {
        S_CLEAR,      // sweep store after reset
        S_IDLE,
        S_WSCAN,      // search write set
        S_WHIT,       // write-set entry data ready
        S_SREAD,      // store read issued
        S_SDATA,      // store data ready
        S_RSCAN,      // search read set
        S_RAPPEND,
        S_CMP,        // cas decision; reads finish, swaps go on to write
        S_W_WSCAN,    // write: search write set
        S_W_RSCAN,    // write: search read set
        S_W_SHIFT,    // close read-set gap
        S_W_APPEND,
        S_C_VREAD,    // commit: read entry
        S_C_VSTORE,   // commit: read store version
        S_C_VCHECK,
        S_C_WREAD,
        S_C_WSTORE,
        S_C_WWRITE,
        S_DONE,
        S_OUT
    } t_state;

endpackage

### rtl/core/transaction_read_write_set_engine.sv
// ----------------------------------------------------------------------------
// transaction_read_write_set_engine
// software-transactional-memory style read/write sets with version validation
// ----------------------------------------------------------------------------
// One word is worked on at a time: a small sequencer scans the context's
// write set and read set one entry a cycle through memories with one read
// and one write port each and one shared compare of variable indices. A
// commit walks the read set entry by entry, checking each version against
// the store, then stores each write-set entry. A failed validation or a hit
// in a set ends the walk early. After reset the store is swept once, and no
// word is accepted during the sweep. The result sits in an output register,
// so the next word can be taken in the cycle after the result is taken.
module transaction_read_write_set_engine #(
    parameter int NUM_VARS      = trwse_pkg::NUM_VARS_DEF,
    parameter int READ_SET_MAX  = trwse_pkg::READ_SET_MAX_DEF,
    parameter int WRITE_SET_MAX = trwse_pkg::WRITE_SET_MAX_DEF,
    parameter int NUM_CONTEXTS  = trwse_pkg::NUM_CONTEXTS_DEF,
    parameter int DATA_WIDTH    = trwse_pkg::DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  trwse_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output trwse_pkg::t_out_word o_data
);

    localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int RW = (READ_SET_MAX > 1) ? $clog2(READ_SET_MAX) : 1;
    localparam int WW = (WRITE_SET_MAX > 1) ? $clog2(WRITE_SET_MAX) : 1;
    localparam int RCW = $clog2(READ_SET_MAX + 1);
    localparam int WCW = $clog2(WRITE_SET_MAX + 1);
    localparam int RD = NUM_CONTEXTS * READ_SET_MAX;
    localparam int WD = NUM_CONTEXTS * WRITE_SET_MAX;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

    // memories
    logic [DATA_WIDTH-1:0] m_sval [NUM_VARS];
    logic [31:0]           m_sver [NUM_VARS];
    logic [VW-1:0]         m_rvar [RD];
    logic [31:0]           m_rver [RD];
    logic [VW-1:0]         m_wvar [WD];
    logic [DATA_WIDTH-1:0] m_wval [WD];

    logic [RCW-1:0] r_rcnt [NUM_CONTEXTS];
    logic [WCW-1:0] r_wcnt [NUM_CONTEXTS];

    trwse_pkg::t_state r_state, n_state;

    // word registers
    logic [2:0]            r_op;
    logic [CW-1:0]         r_ctx;
    logic [VW-1:0]         r_var;
    logic [DATA_WIDTH-1:0] r_wv, r_ev;
    logic [DATA_WIDTH-1:0] r_res;
    logic [1:0]            r_st;
    logic                  r_ok;
    logic [8:0]            r_idx;        // scan index (sets are at most 256)
    logic [VW:0]           r_clr;
    logic [WW-1:0]         r_hit_w;      // write-set hit position, or the append slot after a miss
    logic                  r_ovalid;
    trwse_pkg::t_out_word  r_odata;

    // memory read data, registered
    logic [VW-1:0]         q_rvar, q_wvar;
    logic [31:0]           q_rver, q_sver;
    logic [DATA_WIDTH-1:0] q_wval, q_sval;

    logic [RCW-1:0] rcnt;
    logic [WCW-1:0] wcnt;
    assign rcnt = r_rcnt[r_ctx];
    assign wcnt = r_wcnt[r_ctx];

    logic [RAW-1:0] raddr, raddr_n;
    logic [WAW-1:0] waddr;
    logic [VW-1:0]  saddr;

    // read-set scan address, and the entry two ahead for the gap shift
    assign raddr   = RAW'(r_ctx * READ_SET_MAX + r_idx[RW-1:0]);
    assign raddr_n = RAW'(r_ctx * READ_SET_MAX + r_idx[RW-1:0] + 2);

    logic r_end, w_end;
    assign r_end = ({1'b0, r_idx} >= 10'(rcnt));
    assign w_end = ({1'b0, r_idx} >= 10'(wcnt));

    // the single shared compare of variable indices
    logic [VW-1:0] cmp_a;
    logic          eq;
    always_comb begin
        unique case (r_state)
            trwse_pkg::S_WSCAN, trwse_pkg::S_W_WSCAN: cmp_a = q_wvar;
            default:                                  cmp_a = q_rvar;
        endcase
    end
    assign eq = (cmp_a == r_var);

    logic accept;
    assign o_stall = (r_state != trwse_pkg::S_IDLE) || r_ovalid;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // write-set address: scan index or held hit
    always_comb begin
        if (r_state == trwse_pkg::S_WHIT || r_state == trwse_pkg::S_W_APPEND)
            waddr = WAW'(r_ctx * WRITE_SET_MAX + r_hit_w);
        else
            waddr = WAW'(r_ctx * WRITE_SET_MAX + r_idx[WW-1:0]);
    end

    always_comb begin
        if (r_state == trwse_pkg::S_C_VSTORE) saddr = q_rvar;
        else if (r_state == trwse_pkg::S_C_WSTORE || r_state == trwse_pkg::S_C_WWRITE)
            saddr = q_wvar;
        else saddr = r_var;
    end

    // scans run behind the registered reads: r_idx points at the entry whose
    // data arrives next; a "primed" flag tells whether q_* holds a valid entry
    logic r_prim;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trwse_pkg::S_CLEAR:
                if (r_clr == (VW+1)'(NUM_VARS - 1)) n_state = trwse_pkg::S_IDLE;
            trwse_pkg::S_IDLE:
                if (accept) begin
                    priority case (i_data.operation)
                        trwse_pkg::OP_READ, trwse_pkg::OP_SWAP, trwse_pkg::OP_CAS:
                            n_state = trwse_pkg::S_WSCAN;
                        trwse_pkg::OP_WRITE:  n_state = trwse_pkg::S_W_WSCAN;
                        trwse_pkg::OP_COMMIT: n_state = trwse_pkg::S_C_VREAD;
                        default:              n_state = trwse_pkg::S_DONE;
                    endcase
                end
            trwse_pkg::S_WSCAN:
                if (r_prim && eq) n_state = trwse_pkg::S_WHIT;
                else if (w_end) n_state = trwse_pkg::S_SREAD;
            trwse_pkg::S_WHIT:  n_state = trwse_pkg::S_CMP;
            trwse_pkg::S_SREAD: n_state = trwse_pkg::S_SDATA;
            trwse_pkg::S_SDATA: n_state = trwse_pkg::S_RSCAN;
            trwse_pkg::S_RSCAN:
                if (r_prim && eq) n_state = trwse_pkg::S_CMP;
                else if (r_end) n_state = trwse_pkg::S_RAPPEND;
            trwse_pkg::S_RAPPEND: n_state = trwse_pkg::S_CMP;
            trwse_pkg::S_CMP:
                if (r_op == trwse_pkg::OP_READ) n_state = trwse_pkg::S_DONE;
                else if (r_op == trwse_pkg::OP_CAS && r_res != r_ev) n_state = trwse_pkg::S_DONE;
                else n_state = trwse_pkg::S_W_WSCAN;
            trwse_pkg::S_W_WSCAN:
                if (r_prim && eq) n_state = trwse_pkg::S_DONE;
                else if (w_end) n_state = trwse_pkg::S_W_RSCAN;
            trwse_pkg::S_W_RSCAN:
                if (r_prim && eq) n_state = trwse_pkg::S_W_SHIFT;
                else if (r_end) n_state = trwse_pkg::S_W_APPEND;
            trwse_pkg::S_W_SHIFT:
                if ({1'b0, r_idx} + 10'd1 >= 10'(rcnt)) n_state = trwse_pkg::S_W_APPEND;
            trwse_pkg::S_W_APPEND: n_state = trwse_pkg::S_DONE;
            trwse_pkg::S_C_VREAD:
                if (r_end) n_state = trwse_pkg::S_C_WREAD;
                else n_state = trwse_pkg::S_C_VSTORE;
            trwse_pkg::S_C_VSTORE: n_state = trwse_pkg::S_C_VCHECK;
            trwse_pkg::S_C_VCHECK:
                if (q_sver != q_rver) n_state = trwse_pkg::S_DONE;
                else n_state = trwse_pkg::S_C_VREAD;
            trwse_pkg::S_C_WREAD:
                if (w_end) n_state = trwse_pkg::S_DONE;
                else n_state = trwse_pkg::S_C_WSTORE;
            trwse_pkg::S_C_WSTORE: n_state = trwse_pkg::S_C_WWRITE;
            trwse_pkg::S_C_WWRITE: n_state = trwse_pkg::S_C_WREAD;
            trwse_pkg::S_DONE: n_state = trwse_pkg::S_OUT;
            trwse_pkg::S_OUT:  n_state = trwse_pkg::S_IDLE;
            default: n_state = trwse_pkg::S_IDLE;
        endcase
    end

    // memory reads, always registered
    always_ff @(posedge i_clk) begin
        q_wvar <= m_wvar[waddr];
        q_wval <= m_wval[waddr];
        q_sval <= m_sval[saddr];
        q_sver <= m_sver[saddr];
        if (r_state == trwse_pkg::S_W_SHIFT) begin
            q_rvar <= m_rvar[raddr_n];
            q_rver <= m_rver[raddr_n];
        end else begin
            q_rvar <= m_rvar[raddr];
            q_rver <= m_rver[raddr];
        end
    end

    // gap shift: the next entry was fetched into q_r* the cycle before
    logic [VW-1:0] m_rvar_sh;
    logic [31:0]   m_rver_sh;
    assign m_rvar_sh = q_rvar;
    assign m_rver_sh = q_rver;

    // memory writes: store, read set, write set (one port each)
    always_ff @(posedge i_clk) begin
        if (r_state == trwse_pkg::S_CLEAR) begin
            m_sval[r_clr[VW-1:0]] <= '0;
            m_sver[r_clr[VW-1:0]] <= 32'd1;
        end else if (r_state == trwse_pkg::S_C_WWRITE) begin
            m_sval[saddr] <= q_wval;
            m_sver[saddr] <= q_sver + 32'd1;
        end
        if (r_state == trwse_pkg::S_RAPPEND && rcnt < RCW'(READ_SET_MAX)) begin
            m_rvar[raddr] <= r_var;
            m_rver[raddr] <= q_sver;
        end else if (r_state == trwse_pkg::S_W_SHIFT
                     && {1'b0, r_idx} + 10'd1 < 10'(rcnt)) begin
            m_rvar[raddr] <= m_rvar_sh;
            m_rver[raddr] <= m_rver_sh;
        end
        if (r_state == trwse_pkg::S_W_WSCAN && r_prim && eq) begin
            m_wval[WAW'(r_ctx * WRITE_SET_MAX + r_hit_w)] <= r_wv;
        end else if (r_state == trwse_pkg::S_W_APPEND && wcnt < WCW'(WRITE_SET_MAX)) begin
            m_wvar[waddr] <= r_var;
            m_wval[waddr] <= r_wv;
        end
    end

    // control and word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= trwse_pkg::S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_prim   <= 1'b0;
            r_idx    <= '0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_rcnt[c] <= '0;
                r_wcnt[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                trwse_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                trwse_pkg::S_IDLE: begin
                    r_idx  <= '0;
                    r_prim <= 1'b0;
                    if (accept) begin
                        r_op  <= i_data.operation;
                        r_ctx <= CW'(i_data.context_req % NUM_CONTEXTS);
                        r_var <= VW'(i_data.var_index % NUM_VARS);
                        r_wv  <= DATA_WIDTH'(i_data.write_value);
                        r_ev  <= DATA_WIDTH'(i_data.expected_value);
                        r_res <= '0;
                        r_st  <= trwse_pkg::ST_OK;
                        r_ok  <= 1'b1;
                    end
                end
                trwse_pkg::S_WSCAN, trwse_pkg::S_W_WSCAN: begin
                    if (r_prim && eq) begin
                        // buffered value arrives together with its variable
                        if (r_state == trwse_pkg::S_WSCAN) r_res <= q_wval;
                        r_idx <= '0;
                        r_prim <= 1'b0;
                    end else if (w_end) begin
                        r_idx <= '0;
                        r_prim <= 1'b0;
                        r_hit_w <= WW'(wcnt);
                    end else begin
                        r_hit_w <= r_idx[WW-1:0];
                        r_idx <= r_idx + 1'b1;
                        r_prim <= 1'b1;
                    end
                end
                trwse_pkg::S_SDATA: r_res <= q_sval;
                trwse_pkg::S_RSCAN: begin
                    if (r_prim && eq) begin
                        r_idx <= '0; r_prim <= 1'b0;
                    end else if (!r_end) begin
                        r_idx <= r_idx + 1'b1; r_prim <= 1'b1;
                    end
                end
                trwse_pkg::S_RAPPEND: begin
                    r_idx <= '0; r_prim <= 1'b0;
                    if (rcnt < RCW'(READ_SET_MAX)) r_rcnt[r_ctx] <= rcnt + 1'b1;
                    else r_st <= trwse_pkg::ST_FULL;
                end
                trwse_pkg::S_CMP: begin
                    r_idx <= '0; r_prim <= 1'b0;
                    if (r_op == trwse_pkg::OP_CAS && r_res != r_ev
                        && r_st != trwse_pkg::ST_FULL)
                        r_st <= trwse_pkg::ST_FAIL;
                end
                trwse_pkg::S_W_RSCAN: begin
                    if (r_prim && eq) begin
                        // hit at r_idx-1: step back and fetch the next entry
                        r_idx  <= r_idx - 1'b1;
                        r_prim <= 1'b0;
                    end else if (!r_end) begin
                        r_idx <= r_idx + 1'b1; r_prim <= 1'b1;
                    end
                end
                trwse_pkg::S_W_SHIFT: begin
                    if ({1'b0, r_idx} + 10'd1 >= 10'(rcnt))
                        r_rcnt[r_ctx] <= rcnt - 1'b1;
                    else r_idx <= r_idx + 1'b1;
                end
                trwse_pkg::S_W_APPEND: begin
                    if (wcnt < WCW'(WRITE_SET_MAX)) r_wcnt[r_ctx] <= wcnt + 1'b1;
                    else r_st <= trwse_pkg::ST_FULL;
                end
                trwse_pkg::S_C_VCHECK: begin
                    if (q_sver != q_rver) begin
                        r_ok <= 1'b0;
                        r_st <= trwse_pkg::ST_FAIL;
                    end else r_idx <= r_idx + 1'b1;
                end
                trwse_pkg::S_C_VREAD: if (r_end) r_idx <= '0;
                trwse_pkg::S_C_WWRITE: begin
                    r_res <= q_wval;
                    r_idx <= r_idx + 1'b1;
                end
                trwse_pkg::S_DONE: begin
                    if (r_op == trwse_pkg::OP_COMMIT || r_op == trwse_pkg::OP_ABORT) begin
                        r_rcnt[r_ctx] <= '0;
                        r_wcnt[r_ctx] <= '0;
                    end
                    if (r_op == trwse_pkg::OP_COMMIT && !r_ok) r_res <= '0;
                    if (r_op == trwse_pkg::OP_WRITE) r_res <= '0;
                end
                trwse_pkg::S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == trwse_pkg::S_OUT) begin
            r_odata.result_value <= 32'(r_res);
            r_odata.status       <= r_st;
        end
    end

endmodule
